@@ hdl/modexp_pkg.sv @@
`default_nettype none

package modexp_pkg;

    localparam int BASE_WIDTH     = 32;
    localparam int POWER_WIDTH    = 32;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_IDX_WIDTH  = 1;
    localparam int RED_CNT_WIDTH  = $clog2(BASE_WIDTH);

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_EXPONENT = 1'b1;

    localparam logic [CFG_DATA_WIDTH-1:0] MODULUS_RESET  = 32'd1;
    localparam logic [CFG_DATA_WIDTH-1:0] EXPONENT_RESET = 32'd257;

    typedef struct packed {
        logic [BASE_WIDTH-1:0] base;
        logic                  last_in;
    } in_t;

    typedef struct packed {
        logic [POWER_WIDTH-1:0] power;
        logic                   last_out;
    } out_t;

endpackage

`default_nettype wire

@@ hdl/modular_exponentiation.sv @@
`default_nettype none

// Raises each requested base to the configured exponent modulo the configured modulus,
// one request at a time, with square-and-multiply scanning the exponent from its least
// significant bit. Write the modulus (index 0, low MOD_WIDTH bits kept) and the exponent
// (index 1) only while no request is in flight. A request first reduces the base one bit
// per cycle, then each exponent bit up to the highest set one costs a decision state, a
// squaring and, if the bit is set, a multiplication; each modular multiplication runs one
// multiplier bit per cycle in a shift-and-add unit until the multiplier is zero. A zero
// exponent or a zero modulus skips straight to the finish state. The output register
// lets a result wait for m_ready while the next request is accepted and processed.
module modular_exponentiation #(
    parameter int MOD_WIDTH = 32
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      cfg_we,
    input  wire  [modexp_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  wire  [modexp_pkg::CFG_DATA_WIDTH-1:0]    cfg_wdata,
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  wire  modexp_pkg::in_t                    s_data,
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output modexp_pkg::out_t                         m_data
);

    localparam int W  = MOD_WIDTH;
    localparam int BW = modexp_pkg::BASE_WIDTH;
    localparam int EW = modexp_pkg::CFG_DATA_WIDTH;
    localparam int CW = modexp_pkg::RED_CNT_WIDTH;

    localparam logic [W-1:0] ZERO_W = '0;
    localparam logic [W-1:0] ONE_W  = {{(W-1){1'b0}}, 1'b1};

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_REDUCE  = 3'd1;
    localparam logic [2:0] ST_EXP     = 3'd2;
    localparam logic [2:0] ST_MUL_ACC = 3'd3;
    localparam logic [2:0] ST_SQUARE  = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [W-1:0]      mod_reg, mod_next;
    logic [EW-1:0]     exp_cfg_reg, exp_cfg_next;
    logic              m_valid_reg, m_valid_next;

    logic [EW-1:0]     exp_reg, exp_next;
    logic [BW-1:0]     base_sr_reg, base_sr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]      acc_reg, acc_next;
    logic [W-1:0]      b_reg, b_next;
    logic [W-1:0]      mx_reg, mx_next;
    logic [W-1:0]      my_reg, my_next;
    logic [W-1:0]      mp_reg, mp_next;
    logic              last_reg, last_next;
    modexp_pkg::out_t  out_reg, out_next;

    logic [W+31:0]     cfg_ext;
    logic [W+31:0]     pow_ext;
    logic [W:0]        red_t, red_r;
    logic [W:0]        p_sum, p_add;
    logic [W:0]        x_sum, x_dbl;
    logic              s_accept;
    logic              out_free;

    assign cfg_ext  = {{W{1'b0}}, cfg_wdata};
    assign pow_ext  = {32'b0, acc_reg};
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        red_t = {b_reg, base_sr_reg[BW-1]};
        red_r = (red_t >= {1'b0, mod_reg}) ? red_t - {1'b0, mod_reg} : red_t;
        p_sum = {1'b0, mp_reg} + {1'b0, mx_reg};
        p_add = (p_sum >= {1'b0, mod_reg}) ? p_sum - {1'b0, mod_reg} : p_sum;
        x_sum = {mx_reg, 1'b0};
        x_dbl = (x_sum >= {1'b0, mod_reg}) ? x_sum - {1'b0, mod_reg} : x_sum;
    end

    always_comb begin
        state_next   = state_reg;
        mod_next     = mod_reg;
        exp_cfg_next = exp_cfg_reg;
        m_valid_next = m_valid_reg;
        exp_next     = exp_reg;
        base_sr_next = base_sr_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        b_next       = b_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        mp_next      = mp_reg;
        last_next    = last_reg;
        out_next     = out_reg;

        if (cfg_we) begin
            case (cfg_index)
                modexp_pkg::CFG_MODULUS:  mod_next = cfg_ext[W-1:0];
                modexp_pkg::CFG_EXPONENT: exp_cfg_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    exp_next     = exp_cfg_reg;
                    base_sr_next = s_data.base;
                    last_next    = s_data.last_in;
                    cnt_next     = CW'(BW - 1);
                    b_next       = ZERO_W;
                    if (exp_cfg_reg == '0) begin
                        acc_next   = ONE_W;
                        state_next = ST_FINISH;
                    end else if (mod_reg == ZERO_W) begin
                        acc_next   = ZERO_W;
                        state_next = ST_FINISH;
                    end else begin
                        acc_next   = (mod_reg == ONE_W) ? ZERO_W : ONE_W;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE: begin
                b_next       = red_r[W-1:0];
                base_sr_next = {base_sr_reg[BW-2:0], 1'b0};
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_EXP;
                end
            end
            ST_EXP: begin
                mp_next = ZERO_W;
                if (exp_reg == '0) begin
                    state_next = ST_FINISH;
                end else if (exp_reg[0]) begin
                    mx_next    = acc_reg;
                    my_next    = b_reg;
                    state_next = ST_MUL_ACC;
                end else begin
                    mx_next    = b_reg;
                    my_next    = b_reg;
                    state_next = ST_SQUARE;
                end
            end
            ST_MUL_ACC, ST_SQUARE: begin
                if (my_reg == ZERO_W) begin
                    if (state_reg == ST_MUL_ACC) begin
                        acc_next   = mp_reg;
                        mx_next    = b_reg;
                        my_next    = b_reg;
                        mp_next    = ZERO_W;
                        state_next = ST_SQUARE;
                    end else begin
                        b_next     = mp_reg;
                        exp_next   = {1'b0, exp_reg[EW-1:1]};
                        state_next = ST_EXP;
                    end
                end else begin
                    if (my_reg[0]) begin
                        mp_next = p_add[W-1:0];
                    end
                    mx_next = x_dbl[W-1:0];
                    my_next = {1'b0, my_reg[W-1:1]};
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next.power    = pow_ext[modexp_pkg::POWER_WIDTH-1:0];
                    out_next.last_out = last_reg;
                    m_valid_next      = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mod_reg     <= ONE_W;
            exp_cfg_reg <= modexp_pkg::EXPONENT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mod_reg     <= mod_next;
            exp_cfg_reg <= exp_cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg     <= exp_next;
        base_sr_reg <= base_sr_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        b_reg       <= b_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        mp_reg      <= mp_next;
        last_reg    <= last_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg != ST_IDLE)
        else $error("accepted request did not start processing");

    a_finish_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) && out_free |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("finished result was not loaded into the output register");

    a_mul_shifts: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_MUL_ACC) || (state_reg == ST_SQUARE)) && (my_reg != ZERO_W)
        |=> my_reg == ($past(my_reg) >> 1))
        else $error("multiplier operand did not shift by one bit");

    a_mul_then_square: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_ACC) && (my_reg == ZERO_W) |=> state_reg == ST_SQUARE)
        else $error("accumulator multiply was not followed by a squaring");
`endif

endmodule

`default_nettype wire
